FILE: rtl/cms_pkg.sv
// Package for the concatenating merge sorter: sizes and sequencer state type.
package cms_pkg;

	// Buffer depth and the widths that follow from it
	localparam int DEPTH = 64;
	localparam int DW    = 32;                   // value width
	localparam int AW    = $clog2(DEPTH);        // buffer address
	localparam int CW    = $clog2(DEPTH + 1);    // count up to DEPTH
	localparam int SW    = $clog2(3 * DEPTH + 1); // run bound sums, run width

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PASS,
		ST_RUN_START,
		ST_FETCH_I,
		ST_FETCH_J,
		ST_MERGE,
		ST_REFILL_A,
		ST_REFILL_B,
		ST_RUN_END,
		ST_EMIT_START,
		ST_EMIT
	} state_t;

endpackage

FILE: rtl/cms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/concat_merge_sort.sv
// Top level of the concatenating merge sorter: load, bottom-up merge passes, emission.
//
// Items are taken one per cycle while busy is low; each item lands in the buffer
// (64 entries) and items beyond that are dropped, which sets overflowed on every
// result of the set. The item with is_final high closes the set: busy then stays
// high while the set of n values is sorted and emitted. Sorting runs ceil(log2 n)
// bottom-up merge passes, ping-ponging between two single-port-read RAMs with one
// shared signed comparator; in each pass every value moved needs one RAM read and
// one compare/write step. Emission then presents one result per cycle, after a
// read lead-in step. Each result is shown for exactly one cycle with strobe high
// and cannot be held off; is_last marks the final value.
module concat_merge_sort (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [cms_pkg::DW-1:0] value,
	input  logic                         is_final,
	output logic                         strobe,
	output logic signed [cms_pkg::DW-1:0] sorted_value,
	output logic                         is_last,
	output logic                         overflowed
);
	import cms_pkg::*;

	state_t state_q, state_nxt;

	logic [CW-1:0] fill_q;
	logic          ovf_q;
	logic          src_q;      // bank holding the current source data
	logic [SW-1:0] w_q;        // run width of this pass
	logic [CW-1:0] lo_q, mid_q, hi_q;
	logic [CW-1:0] i_q, j_q, k_q;
	logic signed [DW-1:0] a_q, b_q;

	logic          accept;
	logic          load_we;
	logic          merge_we;
	logic          take_a;
	logic [AW-1:0] rd_addr;
	logic [DW-1:0] rdata0, rdata1, rdata;
	logic [DW-1:0] wdata0, wdata1, merge_data;
	logic [AW-1:0] waddr0, waddr1;
	logic          we0, we1;
	logic [SW-1:0] lo_ext, n_ext, lo_w, lo_2w;
	logic [CW-1:0] mid_c, hi_c;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign load_we = accept && (fill_q < CW'(DEPTH));

	// Run bounds for the run starting at lo
	assign lo_ext = SW'(lo_q);
	assign n_ext  = SW'(fill_q);
	assign lo_w   = lo_ext + w_q;
	assign lo_2w  = lo_ext + (w_q << 1);
	assign mid_c  = (lo_w  < n_ext) ? CW'(lo_w)  : fill_q;
	assign hi_c   = (lo_2w < n_ext) ? CW'(lo_2w) : fill_q;

	// Shared comparator: take left if it remains and right is exhausted or larger
	assign take_a     = (i_q < mid_q) && ((j_q >= hi_q) || (a_q < b_q));
	assign merge_data = take_a ? a_q : b_q;
	assign rdata      = src_q ? rdata1 : rdata0;

	// Bank write steering: loads always fill bank 0, merges write the other bank
	assign we0    = load_we || (merge_we && src_q);
	assign we1    = merge_we && !src_q;
	assign waddr0 = load_we ? fill_q[AW-1:0] : k_q[AW-1:0];
	assign waddr1 = k_q[AW-1:0];
	assign wdata0 = load_we ? value : merge_data;
	assign wdata1 = merge_data;

	cms_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (waddr0),
		.wdata (wdata0),
		.raddr (rd_addr),
		.rdata (rdata0)
	);

	cms_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (waddr1),
		.wdata (wdata1),
		.raddr (rd_addr),
		.rdata (rdata1)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state, read address and merge write enable
	always_comb begin
		state_nxt = state_q;
		rd_addr   = '0;
		merge_we  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_final) begin
					state_nxt = ST_PASS;
				end
			end
			ST_PASS: begin
				state_nxt = (w_q < n_ext) ? ST_RUN_START : ST_EMIT_START;
			end
			ST_RUN_START: begin
				rd_addr   = lo_q[AW-1:0];
				state_nxt = ST_FETCH_I;
			end
			ST_FETCH_I: begin
				rd_addr   = j_q[AW-1:0];
				state_nxt = ST_FETCH_J;
			end
			ST_FETCH_J: begin
				state_nxt = ST_MERGE;
			end
			ST_MERGE: begin
				merge_we = 1'b1;
				if (take_a && (i_q + 1'b1 < mid_q)) begin
					rd_addr   = AW'(i_q + 1'b1);
					state_nxt = ST_REFILL_A;
				end else if (!take_a && (j_q + 1'b1 < hi_q)) begin
					rd_addr   = AW'(j_q + 1'b1);
					state_nxt = ST_REFILL_B;
				end else if (k_q + 1'b1 == hi_q) begin
					state_nxt = ST_RUN_END;
				end
			end
			ST_REFILL_A: begin
				state_nxt = ST_MERGE;
			end
			ST_REFILL_B: begin
				state_nxt = ST_MERGE;
			end
			ST_RUN_END: begin
				state_nxt = (lo_2w >= n_ext) ? ST_PASS : ST_RUN_START;
			end
			ST_EMIT_START: begin
				rd_addr   = '0;
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				rd_addr = AW'(k_q + 1'b1);
				if (k_q + 1'b1 == fill_q) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
			src_q  <= 1'b0;
			strobe <= 1'b0;
		end else begin
			strobe <= (state_q == ST_EMIT);
			if (accept) begin
				if (load_we) begin
					fill_q <= fill_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
				if (is_final) begin
					src_q <= 1'b0;
				end
			end
			if (state_q == ST_RUN_END && lo_2w >= n_ext) begin
				src_q <= !src_q;
			end
			if (state_q == ST_EMIT && k_q + 1'b1 == fill_q) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end
		end
	end

	// Merge indexes, head values and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				w_q <= SW'(1);
			end
			ST_PASS: begin
				lo_q <= '0;
			end
			ST_RUN_START: begin
				mid_q <= mid_c;
				hi_q  <= hi_c;
				i_q   <= lo_q;
				j_q   <= mid_c;
				k_q   <= lo_q;
			end
			ST_FETCH_I: begin
				a_q <= rdata;
			end
			ST_FETCH_J: begin
				b_q <= rdata;
			end
			ST_MERGE: begin
				k_q <= k_q + 1'b1;
				if (take_a) begin
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			ST_REFILL_A: begin
				a_q <= rdata;
			end
			ST_REFILL_B: begin
				b_q <= rdata;
			end
			ST_RUN_END: begin
				if (lo_2w >= n_ext) begin
					w_q <= w_q << 1;
				end else begin
					lo_q <= CW'(lo_2w);
				end
			end
			ST_EMIT_START: begin
				k_q <= '0;
			end
			ST_EMIT: begin
				k_q          <= k_q + 1'b1;
				sorted_value <= rdata;
				is_last      <= (k_q + 1'b1 == fill_q);
				overflowed   <= ovf_q;
			end
			default: begin
			end
		endcase
	end

	// Checks
	a_strobe_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q) == ST_EMIT)
		else $error("result strobe without emission step");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("fill count beyond buffer depth");

	a_merge_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MERGE |-> k_q < hi_q)
		else $error("merge write past end of run");

	a_last_ends_set: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && is_last |=> !strobe)
		else $error("results continue after last item");

endmodule
